>>> design/bdlp_pkg.sv
`default_nettype none

package bdlp_pkg;

    // Field and register widths.
    localparam int ST_W      = 3;
    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int PIN_COUNT = 4;
    localparam int BTN_W     = 2;

    // Button state codes.
    localparam logic [ST_W-1:0] ST_IDLE       = 3'd0;
    localparam logic [ST_W-1:0] ST_DEBOUNCING = 3'd1;
    localparam logic [ST_W-1:0] ST_PRESSED    = 3'd2;
    localparam logic [ST_W-1:0] ST_RELEASED   = 3'd3;
    localparam logic [ST_W-1:0] ST_LONG       = 3'd4;
    localparam logic [ST_W-1:0] ST_LONG_READ  = 3'd5;

    // Operation codes of an input transaction.
    localparam logic FUNC_UPDATE = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 1'b1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // Per-lane command issued when a transaction is accepted.
    typedef struct packed {
        logic upd;      // step the state machine from the pin
        logic ack;      // status of this lane is being read
        logic pin_low;  // sampled pin level, low means pressed
    } lane_cmd_t;

endpackage

`default_nettype wire

>>> design/button_debounce_long_press_core.sv
`default_nettype none

// Debounce and long-press qualifier for NUM_BUTTONS active-low push buttons, one
// state machine lane per button. An update transaction (func 0) samples all pins at
// now_ms and steps every lane at once; it produces no result. A read transaction
// (func 1) returns the status of one button (0 idle, 1 debouncing, 2 pressed,
// 3 released, 4 long press, 5 long press read) and acknowledges it. A new
// transaction is accepted every clock cycle while the output register is empty or
// being drained; the status of a read appears on the output in the cycle after it is
// accepted. Elapsed time is the wrapping difference of now_ms and the stamp taken at
// the start of a press, compared strictly greater than the configured thresholds.
// Buttons with index 4 and above see their pin as released. Configuration writes are
// taken in one cycle and should only be issued while no read result is pending.
module button_debounce_long_press_core
#(
    parameter int NUM_BUTTONS = 4
)
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_we,
    input  wire [bdlp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [bdlp_pkg::CFG_W-1:0]           cfg_data,
    input  wire                                 in_valid,
    output logic                                in_ready,
    input  wire                                 func,
    input  wire [bdlp_pkg::TIME_W-1:0]          now_ms,
    input  wire [bdlp_pkg::PIN_COUNT-1:0]       pins_high,
    input  wire [bdlp_pkg::BTN_W-1:0]           button,
    output logic                                out_valid,
    input  wire                                 out_ready,
    output logic [bdlp_pkg::ST_W-1:0]           status
);

    logic [bdlp_pkg::CFG_W-1:0] debounce_reg;
    logic [bdlp_pkg::CFG_W-1:0] long_press_reg;
    logic                       in_fire;
    logic                       upd_fire;
    logic                       read_fire;
    bdlp_pkg::lane_cmd_t        lane_cmd   [NUM_BUTTONS];
    logic [bdlp_pkg::ST_W-1:0]  lane_state [NUM_BUTTONS];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= bdlp_pkg::DEBOUNCE_RESET;
            long_press_reg <= bdlp_pkg::LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdlp_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_data;
                bdlp_pkg::CFG_LONG_PRESS: long_press_reg <= cfg_data;
                default:                  debounce_reg   <= debounce_reg;
            endcase
        end
    end

    // Input handshake: blocked only while a result waits and is not being taken.
    assign in_ready  = !out_valid || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign upd_fire  = in_fire && (func == bdlp_pkg::FUNC_UPDATE);
    assign read_fire = in_fire && (func == bdlp_pkg::FUNC_READ);

    // One lane per button.
    for (genvar i = 0; i < NUM_BUTTONS; i++)
    begin : g_lane
        assign lane_cmd[i].upd = upd_fire;
        assign lane_cmd[i].ack = read_fire && (int'(button) == i);
        if (i < bdlp_pkg::PIN_COUNT)
        begin : g_pin
            assign lane_cmd[i].pin_low = !pins_high[i];
        end
        else
        begin : g_no_pin
            assign lane_cmd[i].pin_low = 1'b0;
        end

        bdlp_lane u_lane
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (lane_cmd[i]),
            .now_ms        (now_ms),
            .debounce_ms   (debounce_reg),
            .long_press_ms (long_press_reg),
            .state         (lane_state[i])
        );
    end

    // Status selection and output register.
    bdlp_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .lane_state (lane_state),
        .button     (button),
        .load       (read_fire),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status)
    );

    // A pending result that is not taken must stall the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input accepted while result is stalled");

    // Every accepted read presents a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        read_fire |=> out_valid)
        else $error("read transaction produced no result");

    // A read of a missing button reports idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (read_fire && (int'(button) >= NUM_BUTTONS)) |=> (status == bdlp_pkg::ST_IDLE))
        else $error("missing button did not read as idle");

    // An update transaction never loads the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (upd_fire && !out_valid) |=> !out_valid)
        else $error("update transaction produced a result");

endmodule

`default_nettype wire

>>> design/bdlp_lane.sv
`default_nettype none

module bdlp_lane
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire bdlp_pkg::lane_cmd_t         cmd,
    input  wire [bdlp_pkg::TIME_W-1:0]       now_ms,
    input  wire [bdlp_pkg::CFG_W-1:0]        debounce_ms,
    input  wire [bdlp_pkg::CFG_W-1:0]        long_press_ms,
    output logic [bdlp_pkg::ST_W-1:0]        state
);

    logic [bdlp_pkg::ST_W-1:0]   state_reg;
    logic [bdlp_pkg::ST_W-1:0]   state_next;
    logic [bdlp_pkg::TIME_W-1:0] press_time_reg;
    logic [bdlp_pkg::TIME_W-1:0] press_time_next;
    logic [bdlp_pkg::TIME_W-1:0] elapsed;
    logic                        debounce_done;
    logic                        long_done;

    // Wrapping elapsed time since the press was first seen.
    assign elapsed       = now_ms - press_time_reg;
    assign debounce_done =
        elapsed > {{(bdlp_pkg::TIME_W - bdlp_pkg::CFG_W){1'b0}}, debounce_ms};
    assign long_done     =
        elapsed > {{(bdlp_pkg::TIME_W - bdlp_pkg::CFG_W){1'b0}}, long_press_ms};

    // Next state for an update or a status read.
    always_comb
    begin
        state_next      = state_reg;
        press_time_next = press_time_reg;
        if (cmd.upd)
        begin
            case (state_reg)
                bdlp_pkg::ST_IDLE:
                begin
                    if (cmd.pin_low)
                    begin
                        press_time_next = now_ms;
                        state_next      = bdlp_pkg::ST_DEBOUNCING;
                    end
                end
                bdlp_pkg::ST_DEBOUNCING:
                begin
                    if (debounce_done)
                    begin
                        state_next = cmd.pin_low ? bdlp_pkg::ST_PRESSED : bdlp_pkg::ST_IDLE;
                    end
                end
                bdlp_pkg::ST_PRESSED:
                begin
                    if (!cmd.pin_low)
                    begin
                        state_next = bdlp_pkg::ST_RELEASED;
                    end
                    else if (long_done)
                    begin
                        state_next = bdlp_pkg::ST_LONG;
                    end
                end
                bdlp_pkg::ST_RELEASED, bdlp_pkg::ST_LONG:
                begin
                    state_next = state_reg;
                end
                bdlp_pkg::ST_LONG_READ:
                begin
                    if (!cmd.pin_low)
                    begin
                        state_next = bdlp_pkg::ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = bdlp_pkg::ST_IDLE;
                end
            endcase
        end
        else if (cmd.ack)
        begin
            case (state_reg)
                bdlp_pkg::ST_RELEASED: state_next = bdlp_pkg::ST_IDLE;
                bdlp_pkg::ST_LONG:     state_next = bdlp_pkg::ST_LONG_READ;
                default:               state_next = state_reg;
            endcase
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdlp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Press time stamp; only read after it has been written on entry to debouncing.
    always_ff @(posedge clk)
    begin
        press_time_reg <= press_time_next;
    end

    assign state = state_reg;

endmodule

`default_nettype wire

>>> design/bdlp_merge.sv
`default_nettype none

module bdlp_merge
#(
    parameter int NUM_BUTTONS = 4
)
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire [bdlp_pkg::ST_W-1:0]        lane_state [NUM_BUTTONS],
    input  wire [bdlp_pkg::BTN_W-1:0]       button,
    input  wire                             load,
    output logic                            out_valid,
    input  wire                             out_ready,
    output logic [bdlp_pkg::ST_W-1:0]       status
);

    logic [bdlp_pkg::ST_W-1:0] sel_state;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [bdlp_pkg::ST_W-1:0] status_reg;

    // Pick the addressed lane; a missing button reads as idle.
    always_comb
    begin
        sel_state = bdlp_pkg::ST_IDLE;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (int'(button) == i)
            begin
                sel_state = lane_state[i];
            end
        end
    end

    // Output register: filled by a read, emptied when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= sel_state;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;

endmodule

`default_nettype wire

>>> verif/button_debounce_long_press_core_tb.sv
`default_nettype none

module button_debounce_long_press_core_tb;

    localparam int NUM_BTN     = 4;
    localparam int STALL_LIMIT = 2000;

    // One input transaction: a pin scan or a status read.
    typedef struct {
        logic                           fn;
        logic [bdlp_pkg::TIME_W-1:0]    stamp;
        logic [bdlp_pkg::PIN_COUNT-1:0] pins;
        logic [bdlp_pkg::BTN_W-1:0]     btn;
    } button_txn_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [bdlp_pkg::CFG_IDX_W-1:0] cfg_index = bdlp_pkg::CFG_DEBOUNCE;
    logic [bdlp_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           func      = bdlp_pkg::FUNC_UPDATE;
    logic [bdlp_pkg::TIME_W-1:0]    now_ms    = '0;
    logic [bdlp_pkg::PIN_COUNT-1:0] pins_high = '1;
    logic [bdlp_pkg::BTN_W-1:0]     button    = '0;
    logic                           out_ready = 1'b0;
    logic                           in_ready;
    logic                           out_valid;
    logic [bdlp_pkg::ST_W-1:0]      status;

    // Transactions waiting to be sent and statuses waiting to come back.
    button_txn_t               txn_backlog [$];
    logic [bdlp_pkg::ST_W-1:0] status_due [$];

    int txns_issued = 0;
    int txns_taken  = 0;
    int error_count = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    // Predicted block state.
    logic [bdlp_pkg::CFG_W-1:0]  debounce_lim = bdlp_pkg::DEBOUNCE_RESET;
    logic [bdlp_pkg::CFG_W-1:0]  long_lim     = bdlp_pkg::LONG_PRESS_RESET;
    logic [bdlp_pkg::ST_W-1:0]   lane_state [NUM_BTN] = '{default: bdlp_pkg::ST_IDLE};
    logic [bdlp_pkg::TIME_W-1:0] press_stamp [NUM_BTN] = '{default: '0};

    bit                        got_status;
    logic [bdlp_pkg::ST_W-1:0] predicted;
    logic [bdlp_pkg::ST_W-1:0] want;

    button_debounce_long_press_core #(
        .NUM_BUTTONS(NUM_BTN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .now_ms   (now_ms),
        .pins_high(pins_high),
        .button   (button),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status   (status)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Step every button lane on a scan, or report and acknowledge one status on a read.
    task automatic step_button_lanes(input logic fn,
                                     input logic [bdlp_pkg::TIME_W-1:0] stamp,
                                     input logic [bdlp_pkg::PIN_COUNT-1:0] pins,
                                     input logic [bdlp_pkg::BTN_W-1:0] btn,
                                     output bit has_status,
                                     output logic [bdlp_pkg::ST_W-1:0] st);
        logic [bdlp_pkg::TIME_W-1:0] held_ms;
        logic                        low;
        has_status = 1'b0;
        st = bdlp_pkg::ST_IDLE;
        if (fn == bdlp_pkg::FUNC_UPDATE)
        begin
            for (int i = 0; i < NUM_BTN; i++)
            begin
                // Buttons past the pin field always read as released.
                low = (i < bdlp_pkg::PIN_COUNT) ? !pins[i] : 1'b0;
                held_ms = stamp - press_stamp[i];
                case (lane_state[i])
                    bdlp_pkg::ST_IDLE:
                        if (low)
                        begin
                            press_stamp[i] = stamp;
                            lane_state[i] = bdlp_pkg::ST_DEBOUNCING;
                        end
                    bdlp_pkg::ST_DEBOUNCING:
                        if (held_ms > debounce_lim)
                            lane_state[i] = low ? bdlp_pkg::ST_PRESSED : bdlp_pkg::ST_IDLE;
                    bdlp_pkg::ST_PRESSED:
                        if (!low)
                            lane_state[i] = bdlp_pkg::ST_RELEASED;
                        else if (held_ms > long_lim)
                            lane_state[i] = bdlp_pkg::ST_LONG;
                    bdlp_pkg::ST_RELEASED, bdlp_pkg::ST_LONG: ;
                    bdlp_pkg::ST_LONG_READ:
                        if (!low)
                            lane_state[i] = bdlp_pkg::ST_IDLE;
                    default:
                        lane_state[i] = bdlp_pkg::ST_IDLE;
                endcase
            end
        end
        else
        begin
            has_status = 1'b1;
            if (btn < NUM_BTN)
            begin
                st = lane_state[btn];
                if (st == bdlp_pkg::ST_RELEASED)
                    lane_state[btn] = bdlp_pkg::ST_IDLE;
                else if (st == bdlp_pkg::ST_LONG)
                    lane_state[btn] = bdlp_pkg::ST_LONG_READ;
            end
        end
    endtask

    task automatic queue_txn(input logic fn, input logic [bdlp_pkg::TIME_W-1:0] stamp,
                             input logic [bdlp_pkg::PIN_COUNT-1:0] pins,
                             input logic [bdlp_pkg::BTN_W-1:0] btn);
        button_txn_t txn;
        txn.fn = fn;
        txn.stamp = stamp;
        txn.pins = pins;
        txn.btn = btn;
        txn_backlog.push_back(txn);
        txns_issued++;
    endtask

    // Mostly coherent press sequences on a running clock, with some reads and some noise.
    task automatic queue_press_traffic(input int n_items,
                                       input logic [bdlp_pkg::CFG_W-1:0] deb,
                                       input logic [bdlp_pkg::CFG_W-1:0] lp);
        logic [bdlp_pkg::TIME_W-1:0]    clock_ms;
        logic [bdlp_pkg::PIN_COUNT-1:0] level;
        int                             reach;
        reach = lp / 3 + deb + 4;
        if ($urandom_range(0, 3) == 0)
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2 * reach);
        else
            clock_ms = $urandom;
        level = '1;
        for (int k = 0; k < n_items; k++)
        begin
            if ($urandom_range(0, 19) == 0)
                queue_txn($urandom_range(0, 1), $urandom, $urandom_range(0, 15),
                          $urandom_range(0, 3));
            else if ($urandom_range(0, 9) < 3)
                queue_txn(bdlp_pkg::FUNC_READ, $urandom, $urandom_range(0, 15),
                          $urandom_range(0, 3));
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    clock_ms += $urandom_range(0, deb / 2 + 2);
                else
                    clock_ms += $urandom_range(0, reach);
                for (int b = 0; b < bdlp_pkg::PIN_COUNT; b++)
                    if ($urandom_range(0, 7) == 0)
                        level[b] = ~level[b];
                queue_txn(bdlp_pkg::FUNC_UPDATE, clock_ms, level, $urandom_range(0, 3));
            end
        end
    endtask

    // Wait until every transaction is taken and every status has returned.
    task automatic wait_drained();
        while (txns_taken != txns_issued || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_thresholds(input logic [bdlp_pkg::CFG_W-1:0] deb,
                                    input logic [bdlp_pkg::CFG_W-1:0] lp);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= bdlp_pkg::CFG_DEBOUNCE;
        cfg_data <= deb;
        @(posedge clk);
        cfg_index <= bdlp_pkg::CFG_LONG_PRESS;
        cfg_data <= lp;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Input driver: presents the next backlog transaction, with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (txn_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 7))
            begin
                in_valid <= 1'b1;
                func <= txn_backlog[0].fn;
                now_ms <= txn_backlog[0].stamp;
                pins_high <= txn_backlog[0].pins;
                button <= txn_backlog[0].btn;
                void'(txn_backlog.pop_front());
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // Monitor: tracks configuration, predicts each transaction and checks each status.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == bdlp_pkg::CFG_DEBOUNCE)
                    debounce_lim = cfg_data;
                else if (cfg_index == bdlp_pkg::CFG_LONG_PRESS)
                    long_lim = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected status, expected none, got %0d", $time, status);
                    error_count++;
                end
                else
                begin
                    want = status_due.pop_front();
                    if (status !== want)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want, status);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                txns_taken++;
                step_button_lanes(func, now_ms, pins_high, button, got_status, predicted);
                if (got_status)
                    status_due.push_back(predicted);
            end
        end
    end

    // Watchdog on cycles in which no transaction moves.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** button_debounce_long_press_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset thresholds.
        for (int b = 0; b < 4; b++)
            queue_txn(bdlp_pkg::FUNC_READ, '0, '1, b);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'd100, 4'b0000, 2'd0);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'd120, 4'b0101, 2'd0);   // exactly at the limit
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'd121, 4'b1010, 2'd0);   // high pins go idle
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b1111, 2'd0);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'd1121, 4'b1110, 2'd0);  // long press, release
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b1111, 2'd0);
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b1111, 2'd0);
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b1111, 2'd2);
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b1111, 2'd2);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'd1200, 4'b0000, 2'd1);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'd1300, 4'b1111, 2'd3);
        // Press that spans the wrap of the millisecond counter.
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'hFFFF_FFF0, 4'b1110, 2'd0);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'h0000_0010, 4'b1110, 2'd0);
        queue_txn(bdlp_pkg::FUNC_READ, 32'hFFFF_FFFF, 4'b1111, 2'd0);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'h0000_0400, 4'b1110, 2'd0);
        // Long press holds until read.
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'h0000_0401, 4'b1111, 2'd0);
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b0000, 2'd0);
        queue_txn(bdlp_pkg::FUNC_UPDATE, 32'hFFFF_FFFF, 4'b1111, 2'd0);
        queue_txn(bdlp_pkg::FUNC_READ, 32'd0, 4'b0000, 2'd0);

        queue_press_traffic(165, bdlp_pkg::DEBOUNCE_RESET, bdlp_pkg::LONG_PRESS_RESET);

        write_thresholds(16'd0, 16'd0);
        queue_press_traffic(165, 16'd0, 16'd0);

        // A stretch with no gaps on either side.
        write_thresholds(16'd0, 16'hFFFF);
        calm = 1'b1;
        queue_press_traffic(165, 16'd0, 16'hFFFF);

        write_thresholds(16'hFFFF, 16'hFFFF);
        calm = 1'b0;
        queue_press_traffic(165, 16'hFFFF, 16'hFFFF);

        write_thresholds(16'hFFFF, 16'd0);
        queue_press_traffic(165, 16'hFFFF, 16'd0);

        begin
            logic [bdlp_pkg::CFG_W-1:0] deb;
            logic [bdlp_pkg::CFG_W-1:0] lp;
            deb = $urandom_range(1, 200);
            lp = $urandom_range(200, 3000);
            write_thresholds(deb, lp);
            queue_press_traffic(165, deb, lp);
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("** button_debounce_long_press_core: PASSED **");
        else
            $display("** button_debounce_long_press_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
